@@ rtl/swst_pkg.sv @@
// Shared definitions for the shallow-water source-term pipeline.
// Holds default parameters, register indexes, reset values and status codes.
// Depends on nothing.
`default_nettype none
package swst_pkg;

    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int DEFAULT_FRAC_BITS  = 16;
    localparam int ADDR_WIDTH         = 5;
    localparam int SQRT_LATENCY       = 35;
    localparam int MUL_LATENCY        = 2;

    typedef enum logic [2:0] {
        REG_FRICTION_MODE,
        REG_GRAVITY,
        REG_CORIOLIS,
        REG_SLOPE_X,
        REG_SLOPE_Y,
        REG_FRICTION_COEFF,
        REG_DENSITY
    } reg_idx_t;

    localparam logic [31:0] GRAVITY_RESET = 32'd642908;
    localparam logic [30:0] DENSITY_RESET = 31'd65536;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SATURATED = 2'd1;
    localparam logic [1:0] STATUS_DRY       = 2'd2;

endpackage
`default_nettype wire

@@ rtl/swst_delay.sv @@
// Enabled shift-register delay line used to align operands in the pipeline.
// Depends on nothing.
`default_nettype none
module swst_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule
`default_nettype wire

@@ rtl/swst_mul.sv @@
// Two-stage fixed-point multiplier with floor shift and saturation.
// Depends on nothing.
`default_nettype none
module swst_mul #(
    parameter int SAT_W     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic               flag_in,
    output logic signed [31:0] y,
    output logic               flag_out
);
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic signed [63:0] prod_reg, prod_next;
    logic               flag_reg;
    logic signed [63:0] shifted;
    logic signed [31:0] y_reg, y_next;
    logic               flag_out_reg, flag_out_next;

    assign prod_next = 64'(a) * 64'(b);

    always_comb
    begin
        shifted       = prod_reg >>> FRAC_BITS;
        flag_out_next = flag_reg;
        if (shifted > SAT_HI)
        begin
            y_next        = SAT_HI[31:0];
            flag_out_next = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            y_next        = SAT_LO[31:0];
            flag_out_next = 1'b1;
        end
        else
        begin
            y_next = shifted[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= prod_next;
            flag_reg     <= flag_in;
            y_reg        <= y_next;
            flag_out_reg <= flag_out_next;
        end
    end

    assign y        = y_reg;
    assign flag_out = flag_out_reg;
endmodule
`default_nettype wire

@@ rtl/swst_div.sv @@
// Pipelined restoring divider: (a * 2^FRAC_BITS) / b, truncated, saturated.
// One quotient bit per stage. Depends on nothing.
`default_nettype none
module swst_div #(
    parameter int SAT_W     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic        [30:0] b,
    input  logic               flag_in,
    output logic signed [31:0] q,
    output logic               flag_out
);
    localparam int STEPS = 32 + FRAC_BITS;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic [STEPS-1:0] num_reg  [0:STEPS];
    logic [30:0]      rem_reg  [0:STEPS];
    logic [30:0]      dvs_reg  [0:STEPS];
    logic             neg_reg  [0:STEPS];
    logic             flag_reg [0:STEPS];

    logic [31:0] mag_next;
    logic [30:0] dvs_next;

    assign mag_next = a[31] ? (~a + 32'd1) : a;
    assign dvs_next = (b == 31'd0) ? 31'd1 : b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= {mag_next, {FRAC_BITS{1'b0}}};
            rem_reg[0]  <= '0;
            dvs_reg[0]  <= dvs_next;
            neg_reg[0]  <= a[31];
            flag_reg[0] <= flag_in;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[k], num_reg[k][STEPS-1]};
            diff  = trial - {1'b0, dvs_reg[k]};
            ge    = (trial >= {1'b0, dvs_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[30:0] : trial[30:0];
                num_reg[k+1]  <= {num_reg[k][STEPS-2:0], ge};
                dvs_reg[k+1]  <= dvs_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                flag_reg[k+1] <= flag_reg[k];
            end
        end
    end

    logic signed [63:0] qval;
    logic signed [63:0] qsgn;
    logic signed [31:0] q_reg, q_next;
    logic               flag_out_reg, flag_out_next;

    always_comb
    begin
        qval          = $signed({{(64 - STEPS){1'b0}}, num_reg[STEPS]});
        qsgn          = neg_reg[STEPS] ? -qval : qval;
        flag_out_next = flag_reg[STEPS];
        if (qsgn > SAT_HI)
        begin
            q_next        = SAT_HI[31:0];
            flag_out_next = 1'b1;
        end
        else if (qsgn < SAT_LO)
        begin
            q_next        = SAT_LO[31:0];
            flag_out_next = 1'b1;
        end
        else
        begin
            q_next = qsgn[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg        <= q_next;
            flag_out_reg <= flag_out_next;
        end
    end

    assign q        = q_reg;
    assign flag_out = flag_out_reg;
endmodule
`default_nettype wire

@@ rtl/swst_sqrt.sv @@
// Pipelined momentum magnitude: floor(sqrt(x^2 + y^2)), saturated.
// Squares, sum, then one root bit per stage. Depends on nothing.
`default_nettype none
module swst_sqrt #(
    parameter int SAT_W = 32
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    output logic signed [31:0] mag,
    output logic               flag_out
);
    localparam int STEPS = 32;
    localparam logic [31:0] SAT_HI = 32'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);

    logic signed [63:0] sqx_reg, sqy_reg;
    logic [63:0] num_reg  [0:STEPS];
    logic [34:0] rem_reg  [0:STEPS];
    logic [31:0] root_reg [0:STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg     <= 64'(x) * 64'(x);
            sqy_reg     <= 64'(y) * 64'(y);
            num_reg[0]  <= 64'(sqx_reg) + 64'(sqy_reg);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [34:0] shifted;
        logic [34:0] trial;
        logic        ge;

        always_comb
        begin
            shifted = {rem_reg[k][32:0], num_reg[k][63:62]};
            trial   = {1'b0, root_reg[k], 2'b01};
            ge      = (shifted >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? (shifted - trial) : shifted;
                root_reg[k+1] <= {root_reg[k][30:0], ge};
                num_reg[k+1]  <= {num_reg[k][61:0], 2'b00};
            end
        end
    end

    logic signed [31:0] mag_reg;
    logic               flag_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (root_reg[STEPS] > SAT_HI)
            begin
                mag_reg      <= SAT_HI;
                flag_out_reg <= 1'b1;
            end
            else
            begin
                mag_reg      <= root_reg[STEPS];
                flag_out_reg <= 1'b0;
            end
        end
    end

    assign mag      = mag_reg;
    assign flag_out = flag_out_reg;
endmodule
`default_nettype wire

@@ rtl/shallow_water_source_terms.sv @@
// Top level of the shallow-water momentum source-term pipeline.
// Data are Q16.16 by default; the path from input transfer to out_valid runs through
// the chain of square root, two multipliers and three bit-per-stage dividers.
// Throughput: one node per cycle; a stalled output freezes the whole pipeline.
// Reset clears the valid bits and loads the register defaults.
// Uses swst_pkg, swst_mul, swst_div, swst_sqrt and swst_delay.
`default_nettype none
module shallow_water_source_terms #(
    parameter int DATA_WIDTH = swst_pkg::DEFAULT_DATA_WIDTH,
    parameter int FRAC_BITS  = swst_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swst_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [30:0]                     depth,
    input  logic signed [31:0]              momentum_x,
    input  logic signed [31:0]              momentum_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [31:0]              source_x,
    output logic signed [31:0]              source_y,
    output logic [1:0]                      status
);
    import swst_pkg::*;

    localparam int SAT_W  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int LD     = 34 + FRAC_BITS;
    localparam int T_T1   = SQRT_LATENCY + MUL_LATENCY;
    localparam int T_NORM = T_T1 + LD;
    localparam int T_P    = T_NORM + MUL_LATENCY;
    localparam int T_D2   = T_P + LD;
    localparam int T_F    = T_D2 + LD;
    localparam int VLEN   = T_F + 2;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic               mode_reg;
    logic signed [31:0] gravity_reg, coriolis_reg, slope_x_reg, slope_y_reg, friction_reg;
    logic [30:0]        density_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            gravity_reg  <= GRAVITY_RESET;
            coriolis_reg <= '0;
            slope_x_reg  <= '0;
            slope_y_reg  <= '0;
            friction_reg <= '0;
            density_reg  <= DENSITY_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_FRICTION_MODE:  mode_reg     <= pwdata[0];
                REG_GRAVITY:        gravity_reg  <= pwdata;
                REG_CORIOLIS:       coriolis_reg <= pwdata;
                REG_SLOPE_X:        slope_x_reg  <= pwdata;
                REG_SLOPE_Y:        slope_y_reg  <= pwdata;
                REG_FRICTION_COEFF: friction_reg <= pwdata;
                REG_DENSITY:        density_reg  <= pwdata[30:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_FRICTION_MODE:  prdata = {31'd0, mode_reg};
            REG_GRAVITY:        prdata = gravity_reg;
            REG_CORIOLIS:       prdata = coriolis_reg;
            REG_SLOPE_X:        prdata = slope_x_reg;
            REG_SLOPE_Y:        prdata = slope_y_reg;
            REG_FRICTION_COEFF: prdata = friction_reg;
            REG_DENSITY:        prdata = {1'b0, density_reg};
            default:            prdata = '0;
        endcase
    end

    // The whole pipeline advances together whenever the output stage can move.
    logic            en;
    logic [VLEN-1:0] valid_reg;

    assign en       = !valid_reg[VLEN-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[VLEN-2:0], in_valid};
        end
    end

    logic [30:0]        h_reg;
    logic signed [31:0] hu_reg, hv_reg;
    logic               dry;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg  <= depth;
            hu_reg <= momentum_x;
            hv_reg <= momentum_y;
        end
    end

    assign dry = mode_reg && (h_reg == 31'd0);

    logic signed [31:0] cor_x, cor_y, gs_x, gs_y, fm_x, fm_y, grav_x, grav_y;
    logic               cor_x_f, cor_y_f, gs_x_f, gs_y_f, fm_x_f, fm_y_f, grav_x_f, grav_y_f;
    logic [30:0]        h_d2, h_d37, h_d3;

    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_cor_x (.clk, .en,
        .a(coriolis_reg), .b(hv_reg), .flag_in(1'b0), .y(cor_x), .flag_out(cor_x_f));
    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_cor_y (.clk, .en,
        .a(coriolis_reg), .b(hu_reg), .flag_in(1'b0), .y(cor_y), .flag_out(cor_y_f));
    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_gs_x (.clk, .en,
        .a(gravity_reg), .b(slope_x_reg), .flag_in(1'b0), .y(gs_x), .flag_out(gs_x_f));
    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_gs_y (.clk, .en,
        .a(gravity_reg), .b(slope_y_reg), .flag_in(1'b0), .y(gs_y), .flag_out(gs_y_f));
    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_fm_x (.clk, .en,
        .a(friction_reg), .b(hu_reg), .flag_in(1'b0), .y(fm_x), .flag_out(fm_x_f));
    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_fm_y (.clk, .en,
        .a(friction_reg), .b(hv_reg), .flag_in(1'b0), .y(fm_y), .flag_out(fm_y_f));

    swst_delay #(.WIDTH(31), .DEPTH(MUL_LATENCY)) u_h_d2 (.clk, .en, .d(h_reg), .q(h_d2));

    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_grav_x (.clk, .en,
        .a(gs_x), .b({1'b0, h_d2}), .flag_in(gs_x_f), .y(grav_x), .flag_out(grav_x_f));
    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_grav_y (.clk, .en,
        .a(gs_y), .b({1'b0, h_d2}), .flag_in(gs_y_f), .y(grav_y), .flag_out(grav_y_f));

    logic signed [31:0] mag, t1, norm, p_x, p_y;
    logic               mag_f, t1_f, norm_f, p_x_f, p_y_f;
    logic [63:0]        huv_d;

    swst_sqrt #(.SAT_W(SAT_W)) u_sqrt (.clk, .en, .x(hu_reg), .y(hv_reg),
        .mag(mag), .flag_out(mag_f));

    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_t1 (.clk, .en,
        .a(friction_reg), .b(mag), .flag_in(mag_f), .y(t1), .flag_out(t1_f));

    swst_delay #(.WIDTH(31), .DEPTH(T_T1)) u_h_d37 (.clk, .en, .d(h_reg), .q(h_d37));

    swst_div #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_norm (.clk, .en,
        .a(t1), .b(h_d37), .flag_in(t1_f), .q(norm), .flag_out(norm_f));

    swst_delay #(.WIDTH(64), .DEPTH(T_NORM)) u_huv_d (.clk, .en,
        .d({hu_reg, hv_reg}), .q(huv_d));

    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_p_x (.clk, .en,
        .a(norm), .b(huv_d[63:32]), .flag_in(norm_f), .y(p_x), .flag_out(p_x_f));
    swst_mul #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_p_y (.clk, .en,
        .a(norm), .b(huv_d[31:0]), .flag_in(norm_f), .y(p_y), .flag_out(p_y_f));

    logic [65:0]        fm_d;
    logic signed [31:0] n2_x, n2_y, d2_x, d2_y, d3_x, d3_y;
    logic               n2_x_f, n2_y_f, d2_x_f, d2_y_f, d3_x_f, d3_y_f;

    swst_delay #(.WIDTH(66), .DEPTH(T_P - MUL_LATENCY)) u_fm_d (.clk, .en,
        .d({fm_x_f, fm_x, fm_y_f, fm_y}), .q(fm_d));

    assign n2_x   = mode_reg ? p_x   : fm_d[64:33];
    assign n2_x_f = mode_reg ? p_x_f : fm_d[65];
    assign n2_y   = mode_reg ? p_y   : fm_d[31:0];
    assign n2_y_f = mode_reg ? p_y_f : fm_d[32];

    swst_div #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_d2_x (.clk, .en,
        .a(n2_x), .b(density_reg), .flag_in(n2_x_f), .q(d2_x), .flag_out(d2_x_f));
    swst_div #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_d2_y (.clk, .en,
        .a(n2_y), .b(density_reg), .flag_in(n2_y_f), .q(d2_y), .flag_out(d2_y_f));

    swst_delay #(.WIDTH(31), .DEPTH(T_D2)) u_h_d3 (.clk, .en, .d(h_reg), .q(h_d3));

    swst_div #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_d3_x (.clk, .en,
        .a(d2_x), .b(h_d3), .flag_in(d2_x_f), .q(d3_x), .flag_out(d3_x_f));
    swst_div #(.SAT_W(SAT_W), .FRAC_BITS(FRAC_BITS)) u_d3_y (.clk, .en,
        .a(d2_y), .b(h_d3), .flag_in(d2_y_f), .q(d3_y), .flag_out(d3_y_f));

    logic [65:0] lin_d;
    logic [65:0] cor_d;
    logic [65:0] grav_d;
    logic        dry_d;

    swst_delay #(.WIDTH(66), .DEPTH(LD)) u_lin_d (.clk, .en,
        .d({d2_x_f, d2_x, d2_y_f, d2_y}), .q(lin_d));
    swst_delay #(.WIDTH(66), .DEPTH(T_F - MUL_LATENCY)) u_cor_d (.clk, .en,
        .d({cor_x_f, cor_x, cor_y_f, cor_y}), .q(cor_d));
    swst_delay #(.WIDTH(66), .DEPTH(T_F - 2 * MUL_LATENCY)) u_grav_d (.clk, .en,
        .d({grav_x_f, grav_x, grav_y_f, grav_y}), .q(grav_d));
    swst_delay #(.WIDTH(1), .DEPTH(T_F)) u_dry_d (.clk, .en, .d(dry), .q(dry_d));

    logic signed [31:0] fr_x, fr_y;
    logic               fr_f;
    logic signed [63:0] sum_x, sum_y;
    logic signed [31:0] source_x_reg, source_x_next, source_y_reg, source_y_next;
    logic [1:0]         status_reg, status_next;
    logic               clip;

    always_comb
    begin
        if (dry_d)
        begin
            fr_x = '0;
            fr_y = '0;
            fr_f = 1'b0;
        end
        else if (mode_reg)
        begin
            fr_x = d3_x;
            fr_y = d3_y;
            fr_f = d3_x_f || d3_y_f;
        end
        else
        begin
            fr_x = lin_d[64:33];
            fr_y = lin_d[31:0];
            fr_f = lin_d[65] || lin_d[32];
        end

        sum_x = 64'(signed'(cor_d[64:33])) + 64'(signed'(grav_d[64:33])) - 64'(fr_x);
        sum_y = 64'(signed'(grav_d[31:0])) - 64'(signed'(cor_d[31:0])) - 64'(fr_y);
        clip  = fr_f || cor_d[65] || cor_d[32] || grav_d[65] || grav_d[32];

        if (sum_x > SAT_HI)
        begin
            source_x_next = SAT_HI[31:0];
            clip          = 1'b1;
        end
        else if (sum_x < SAT_LO)
        begin
            source_x_next = SAT_LO[31:0];
            clip          = 1'b1;
        end
        else
        begin
            source_x_next = sum_x[31:0];
        end

        if (sum_y > SAT_HI)
        begin
            source_y_next = SAT_HI[31:0];
            clip          = 1'b1;
        end
        else if (sum_y < SAT_LO)
        begin
            source_y_next = SAT_LO[31:0];
            clip          = 1'b1;
        end
        else
        begin
            source_y_next = sum_y[31:0];
        end

        if (dry_d)
        begin
            status_next = STATUS_DRY;
        end
        else if (clip)
        begin
            status_next = STATUS_SATURATED;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            source_x_reg <= source_x_next;
            source_y_reg <= source_y_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = valid_reg[VLEN-1];
    assign source_x  = source_x_reg;
    assign source_y  = source_y_reg;
    assign status    = status_reg;
endmodule
`default_nettype wire

@@ rtl/swst_checker.sv @@
// Port-level checks for the shallow-water source-term block, bound to its top level.
// Depends on swst_pkg.
`default_nettype none
module swst_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pready,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [31:0]              source_x,
    input logic signed [31:0]              source_y,
    input logic [1:0]                      status
);
    import swst_pkg::*;

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(source_x)
        && $stable(source_y) && $stable(status))
        else $error("stalled output transfer changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_SATURATED
        || status == STATUS_DRY))
        else $error("undefined status code");
endmodule

bind shallow_water_source_terms swst_checker u_swst_checker (
    .clk(clk),
    .rst_n(rst_n),
    .pready(pready),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .source_x(source_x),
    .source_y(source_y),
    .status(status)
);
`default_nettype wire
